/* rtl/core/priority_scheduler_with_aging_assert.svh */
// Assertion macros for the priority scheduler with aging.
// Used by the top level; expects clk and arst_n in scope.
`ifndef PRIORITY_SCHEDULER_WITH_AGING_ASSERT_SVH
`define PRIORITY_SCHEDULER_WITH_AGING_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PSA_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scheduler assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define PSA_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scheduler assertion failed: next-cycle implication");

`endif

/* rtl/core/psa_pkg.sv */
// Shared types and constants of the priority scheduler with aging.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package psa_pkg;

	localparam int NUM_ENTRIES = 64;
	localparam int IDX_W       = $clog2(NUM_ENTRIES);
	localparam int CNT_W       = $clog2(NUM_ENTRIES + 1);
	localparam int FIELD_IDX_W = 6;
	localparam int PRIO_W      = 4;
	localparam int ST_W        = 3;

	// task status codes
	localparam logic [ST_W-1:0] ST_FREE     = 3'd0;
	localparam logic [ST_W-1:0] ST_DYING    = 3'd1;
	localparam logic [ST_W-1:0] ST_RUNNABLE = 3'd2;
	localparam logic [ST_W-1:0] ST_RUNNING  = 3'd3;

	// request opcodes
	localparam logic [1:0] OP_SET_STATUS = 2'd0;
	localparam logic [1:0] OP_CREATE     = 2'd1;
	localparam logic [1:0] OP_SCHEDULE   = 2'd2;

	// decision codes
	localparam logic [1:0] DEC_RUN  = 2'd0;
	localparam logic [1:0] DEC_KEEP = 2'd1;
	localparam logic [1:0] DEC_HALT = 2'd2;
	localparam logic [1:0] DEC_NONE = 2'd3;

	// register indexes on the configuration port
	localparam logic REG_PRIO_MIN = 1'b0;
	localparam logic REG_PRIO_MAX = 1'b1;

	typedef struct packed {
		logic [1:0]             opcode;
		logic [FIELD_IDX_W-1:0] entry_index;
		logic [ST_W-1:0]        entry_state;
		logic [PRIO_W-1:0]      entry_priority;
		logic                   current_valid;
		logic [FIELD_IDX_W-1:0] current_index;
		logic                   current_on_this_cpu;
	} req_t;

	typedef struct packed {
		logic [1:0]             decision;
		logic [FIELD_IDX_W-1:0] chosen_index;
	} rsp_t;

	typedef struct packed {
		logic [PRIO_W-1:0] prio_min;
		logic [PRIO_W-1:0] prio_max;
	} cfg_t;

	// table access from the sequencer
	typedef struct packed {
		logic              rd_en;
		logic [IDX_W-1:0]  rd_addr;
		logic              st_we;
		logic [IDX_W-1:0]  st_waddr;
		logic [ST_W-1:0]   st_wdata;
		logic              pr_we;
		logic [IDX_W-1:0]  pr_waddr;
		logic [PRIO_W-1:0] pr_prio;
		logic              pr_has_run;
	} tbl_req_t;

	typedef struct packed {
		logic [ST_W-1:0]   status;
		logic [PRIO_W-1:0] prio;
		logic              has_run;
	} tbl_rd_t;

endpackage

/* rtl/core/priority_scheduler_with_aging.sv */
// Top level of the priority scheduler with aging: request sequencer,
// result register and assertions. Depends on psa_pkg, psa_cfg, psa_table
// and priority_scheduler_with_aging_assert.svh.
//
// The block keeps a table of 64 tasks (status, priority, has-run flag) in
// two single-port-read memories and serves one request at a time. A set
// status or create request is written on accept and gives no result. A
// schedule request reads the whole table once, one entry a cycle starting
// just after the current task, and picks the runnable entry with the
// lowest priority number (first met wins a tie, levels above prio_max are
// never picked). Aging writes the pick back in the FINISH state; picking
// an entry at prio_max instead starts a second full read-modify-write pass
// that moves every runnable entry to prio_min. Both passes walk the single
// memory read port. The next request is taken as soon as the result sits
// in the output register, even while it is stalled there. The table
// clears at reset at once through per-entry valid bits, so there is no
// clearing pass.
// Write prio_min and prio_max only while no schedule request is in flight.
`timescale 1ns / 1ps

module priority_scheduler_with_aging (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  psa_pkg::req_t     req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output psa_pkg::rsp_t     rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	typedef enum logic [2:0] {
		IDLE,
		SCAN,
		FINISH,
		RESET_PASS,
		DONE
	} state_t;

	state_t                          state_q;
	psa_pkg::cfg_t                   cfg;
	psa_pkg::tbl_req_t               tbl_req;
	psa_pkg::tbl_rd_t                tbl_rd;

	// scan position
	logic [psa_pkg::IDX_W-1:0]       addr_q;
	logic [psa_pkg::IDX_W-1:0]       addr_next;
	logic [psa_pkg::CNT_W-1:0]       iss_q;
	logic                            rv_s1;
	logic                            last_s1;
	logic [psa_pkg::IDX_W-1:0]       raddr_s1;

	// latched schedule request
	logic                            cur_valid_q;
	logic [psa_pkg::FIELD_IDX_W-1:0] cur_q;
	logic                            on_cpu_q;

	// scan results
	logic [psa_pkg::PRIO_W:0]        best_q;
	logic [psa_pkg::IDX_W-1:0]       pick_q;
	logic                            pick_hr_q;
	logic                            found_q;
	logic                            live_q;
	logic                            cur_run_q;

	// decision waiting for the output register
	logic [1:0]                      dec_q;
	logic [psa_pkg::FIELD_IDX_W-1:0] chosen_q;

	logic [psa_pkg::FIELD_IDX_W:0]   cur_inc;
	logic [psa_pkg::IDX_W-1:0]       start_c;
	logic                            wr_in_range;
	logic                            cur_in_range;
	logic                            reset_trig;
	logic                            done_load;

	psa_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	psa_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (tbl_req),
		.rd     (tbl_rd)
	);

	// take requests only between schedules
	assign req_stall = (state_q != IDLE);

	// scan starts just after the current task (entry zero without one), wrapping at the table end
	always_comb begin
		cur_inc = {1'b0, req.current_index} + 1'b1;
		if (!req.current_valid)
			start_c = '0;
		else if (int'(cur_inc) >= psa_pkg::NUM_ENTRIES)
			start_c = psa_pkg::IDX_W'(int'(cur_inc) - psa_pkg::NUM_ENTRIES);
		else
			start_c = psa_pkg::IDX_W'(cur_inc);
	end

	assign addr_next    = (int'(addr_q) == psa_pkg::NUM_ENTRIES - 1) ? '0 : addr_q + 1'b1;
	assign wr_in_range  = int'(req.entry_index) < psa_pkg::NUM_ENTRIES;
	assign cur_in_range = int'(cur_q) < psa_pkg::NUM_ENTRIES;
	assign reset_trig   = (best_q == {1'b0, cfg.prio_max});
	assign done_load    = (state_q == DONE) && (!rsp_valid || !rsp_stall);

	// table port: entry writes when idle, reads while scanning, write-backs
	always_comb begin
		tbl_req            = '0;
		tbl_req.rd_addr    = addr_q;
		tbl_req.rd_en      = ((state_q == SCAN) || (state_q == RESET_PASS)) &&
		                     (int'(iss_q) < psa_pkg::NUM_ENTRIES);
		case (state_q)
			IDLE: begin
				tbl_req.st_we      = req_valid && wr_in_range &&
				                     ((req.opcode == psa_pkg::OP_SET_STATUS) ||
				                      (req.opcode == psa_pkg::OP_CREATE));
				tbl_req.st_waddr   = psa_pkg::IDX_W'(req.entry_index);
				tbl_req.st_wdata   = req.entry_state;
				tbl_req.pr_we      = req_valid && wr_in_range &&
				                     (req.opcode == psa_pkg::OP_CREATE);
				tbl_req.pr_waddr   = psa_pkg::IDX_W'(req.entry_index);
				tbl_req.pr_prio    = req.entry_priority;
				tbl_req.pr_has_run = 1'b0;
			end
			FINISH: begin
				// age the pick by one level if it has run before
				tbl_req.pr_we      = found_q && !reset_trig;
				tbl_req.pr_waddr   = pick_q;
				tbl_req.pr_prio    = pick_hr_q ? best_q[psa_pkg::PRIO_W-1:0] + 1'b1
				                               : best_q[psa_pkg::PRIO_W-1:0];
				tbl_req.pr_has_run = 1'b1;
			end
			RESET_PASS: begin
				// drop every runnable entry to prio_min, mark the pick as run
				tbl_req.pr_we      = rv_s1 && (tbl_rd.status == psa_pkg::ST_RUNNABLE);
				tbl_req.pr_waddr   = raddr_s1;
				tbl_req.pr_prio    = cfg.prio_min;
				tbl_req.pr_has_run = (raddr_s1 == pick_q) ? 1'b1 : tbl_rd.has_run;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			rsp_valid   <= 1'b0;
			rsp         <= '0;
			rv_s1       <= 1'b0;
			last_s1     <= 1'b0;
			raddr_s1    <= '0;
			addr_q      <= '0;
			iss_q       <= '0;
			cur_valid_q <= 1'b0;
			cur_q       <= '0;
			on_cpu_q    <= 1'b0;
			best_q      <= '0;
			pick_q      <= '0;
			pick_hr_q   <= 1'b0;
			found_q     <= 1'b0;
			live_q      <= 1'b0;
			cur_run_q   <= 1'b0;
			dec_q       <= psa_pkg::DEC_RUN;
			chosen_q    <= '0;
		end else begin
			rv_s1    <= tbl_req.rd_en;
			last_s1  <= (int'(iss_q) == psa_pkg::NUM_ENTRIES - 1);
			raddr_s1 <= addr_q;

			// load a finished decision, or drop the result the downstream side took
			if (done_load)
				rsp_valid <= 1'b1;
			else if (rsp_valid && !rsp_stall)
				rsp_valid <= 1'b0;

			case (state_q)
				IDLE: begin
					if (req_valid && (req.opcode == psa_pkg::OP_SCHEDULE)) begin
						cur_valid_q <= req.current_valid;
						cur_q       <= req.current_index;
						on_cpu_q    <= req.current_on_this_cpu;
						addr_q      <= start_c;
						iss_q       <= '0;
						best_q      <= {1'b0, cfg.prio_max} + 1'b1;
						found_q     <= 1'b0;
						live_q      <= 1'b0;
						cur_run_q   <= 1'b0;
						state_q     <= SCAN;
					end
				end
				SCAN: begin
					if (tbl_req.rd_en) begin
						addr_q <= addr_next;
						iss_q  <= iss_q + 1'b1;
					end
					if (rv_s1) begin
						if ((tbl_rd.status == psa_pkg::ST_RUNNABLE) &&
						    ({1'b0, tbl_rd.prio} < best_q)) begin
							best_q    <= {1'b0, tbl_rd.prio};
							pick_q    <= raddr_s1;
							pick_hr_q <= tbl_rd.has_run;
							found_q   <= 1'b1;
						end
						if ((tbl_rd.status == psa_pkg::ST_RUNNABLE) ||
						    (tbl_rd.status == psa_pkg::ST_RUNNING) ||
						    (tbl_rd.status == psa_pkg::ST_DYING))
							live_q <= 1'b1;
						if ((int'(raddr_s1) == int'(cur_q)) &&
						    (tbl_rd.status == psa_pkg::ST_RUNNING))
							cur_run_q <= 1'b1;
						if (last_s1)
							state_q <= FINISH;
					end
				end
				FINISH: begin
					if (found_q) begin
						dec_q    <= psa_pkg::DEC_RUN;
						chosen_q <= psa_pkg::FIELD_IDX_W'(pick_q);
						if (reset_trig) begin
							addr_q  <= '0;
							iss_q   <= '0;
							state_q <= RESET_PASS;
						end else begin
							state_q <= DONE;
						end
					end else begin
						if (cur_valid_q && on_cpu_q && cur_in_range && cur_run_q) begin
							dec_q    <= psa_pkg::DEC_KEEP;
							chosen_q <= cur_q;
						end else if (live_q) begin
							dec_q    <= psa_pkg::DEC_HALT;
							chosen_q <= '0;
						end else begin
							dec_q    <= psa_pkg::DEC_NONE;
							chosen_q <= '0;
						end
						state_q <= DONE;
					end
				end
				RESET_PASS: begin
					if (tbl_req.rd_en) begin
						addr_q <= addr_next;
						iss_q  <= iss_q + 1'b1;
					end
					if (rv_s1 && last_s1)
						state_q <= DONE;
				end
				DONE: begin
					// hold the decision until the output register is free
					if (done_load) begin
						rsp.decision     <= dec_q;
						rsp.chosen_index <= chosen_q;
						state_q          <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

`include "priority_scheduler_with_aging_assert.svh"

	// a finished decision always lands in the output register
	`PSA_ASSERT_NXT(a_done_loads, done_load, rsp_valid)
	// outside the sequencer passes only a create request writes priorities
	`PSA_ASSERT_IMP(a_idle_pr_write, (state_q == IDLE) && tbl_req.pr_we, req_valid && (req.opcode == psa_pkg::OP_CREATE))
	// halt and no-tasks always report entry zero
	`PSA_ASSERT_IMP(a_idle_index, rsp_valid && ((rsp.decision == psa_pkg::DEC_HALT) || (rsp.decision == psa_pkg::DEC_NONE)), rsp.chosen_index == '0)

endmodule

/* rtl/core/psa_cfg.sv */
// APB-style register file for the priority scheduler: prio_min and prio_max.
// Depends on psa_pkg.
`timescale 1ns / 1ps

module psa_cfg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output psa_pkg::cfg_t     cfg
);

	logic [psa_pkg::PRIO_W-1:0] prio_min_q;
	logic [psa_pkg::PRIO_W-1:0] prio_max_q;
	logic                       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prio_min_q <= 4'd1;
			prio_max_q <= 4'd10;
		end else if (wr_en) begin
			case (paddr[2])
				psa_pkg::REG_PRIO_MIN: prio_min_q <= pwdata[psa_pkg::PRIO_W-1:0];
				psa_pkg::REG_PRIO_MAX: prio_max_q <= pwdata[psa_pkg::PRIO_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			psa_pkg::REG_PRIO_MIN: prdata = {28'd0, prio_min_q};
			psa_pkg::REG_PRIO_MAX: prdata = {28'd0, prio_max_q};
			default:               prdata = 32'd0;
		endcase
	end

	assign cfg.prio_min = prio_min_q;
	assign cfg.prio_max = prio_max_q;

endmodule

/* rtl/core/psa_table.sv */
// Task table: status memory and priority/has-run memory, registered read.
// Valid bits per entry make unwritten entries read as zero. Depends on psa_pkg.
`timescale 1ns / 1ps

module psa_table (
	input  logic                clk,
	input  logic                arst_n,
	input  psa_pkg::tbl_req_t   req,
	output psa_pkg::tbl_rd_t    rd
);

	logic [psa_pkg::ST_W-1:0]   st_mem [psa_pkg::NUM_ENTRIES];
	logic [psa_pkg::PRIO_W:0]   pr_mem [psa_pkg::NUM_ENTRIES];
	logic [psa_pkg::NUM_ENTRIES-1:0] st_vld_q;
	logic [psa_pkg::NUM_ENTRIES-1:0] pr_vld_q;

	logic [psa_pkg::ST_W-1:0]   st_rd_s1;
	logic [psa_pkg::PRIO_W:0]   pr_rd_s1;
	logic                       st_vld_s1;
	logic                       pr_vld_s1;

	always_ff @(posedge clk) begin
		if (req.st_we)
			st_mem[req.st_waddr] <= req.st_wdata;
		if (req.pr_we)
			pr_mem[req.pr_waddr] <= {req.pr_prio, req.pr_has_run};
		if (req.rd_en) begin
			st_rd_s1 <= st_mem[req.rd_addr];
			pr_rd_s1 <= pr_mem[req.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_vld_q  <= '0;
			pr_vld_q  <= '0;
			st_vld_s1 <= 1'b0;
			pr_vld_s1 <= 1'b0;
		end else begin
			if (req.st_we)
				st_vld_q[req.st_waddr] <= 1'b1;
			if (req.pr_we)
				pr_vld_q[req.pr_waddr] <= 1'b1;
			if (req.rd_en) begin
				st_vld_s1 <= st_vld_q[req.rd_addr];
				pr_vld_s1 <= pr_vld_q[req.rd_addr];
			end
		end
	end

	// an entry never written reads as the reset value
	assign rd.status  = st_vld_s1 ? st_rd_s1 : psa_pkg::ST_FREE;
	assign rd.prio    = pr_vld_s1 ? pr_rd_s1[psa_pkg::PRIO_W:1] : '0;
	assign rd.has_run = pr_vld_s1 ? pr_rd_s1[0] : 1'b0;

endmodule

/* sim/psa_checker.sv */
// Scoreboard for the priority scheduler with aging: watches the request,
// result and register port traffic, predicts each decision and compares.
// Depends on psa_pkg.
`timescale 1ns / 1ps

module psa_checker
	import psa_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  logic        req_stall,
	input  req_t        req,
	input  logic        rsp_valid,
	input  logic        rsp_stall,
	input  rsp_t        rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic [31:0] prdata,
	input  logic        pready,
	output int unsigned errors,
	output int unsigned pending,
	output int unsigned checked,
	output int unsigned resets
);

	logic [ST_W-1:0]   task_state [NUM_ENTRIES];
	logic [PRIO_W-1:0] task_prio  [NUM_ENTRIES];
	logic              task_ran   [NUM_ENTRIES];
	logic [PRIO_W-1:0] lvl_min;
	logic [PRIO_W-1:0] lvl_max;
	rsp_t              decisions_due [$];
	int unsigned       err_cnt;
	int unsigned       chk_cnt;
	int unsigned       rst_cnt;

	function automatic void flag(input string msg);
		err_cnt++;
		if (err_cnt <= 10) begin
			$display("%s", msg);
		end
	endfunction

	// Pick the next task and apply aging or the global priority reset.
	function automatic rsp_t schedule_decision(input req_t r);
		int   first;
		int   slot;
		int   best;
		int   pick;
		bit   found;
		rsp_t d;
		first = r.current_valid ? (int'(r.current_index) + 1) % NUM_ENTRIES : 0;
		best  = int'(lvl_max) + 1;
		found = 1'b0;
		pick  = 0;
		d     = '0;
		for (int i = 0; i < NUM_ENTRIES; i++) begin
			slot = (first + i) % NUM_ENTRIES;
			if (task_state[slot] == ST_RUNNABLE && int'(task_prio[slot]) < best) begin
				best  = int'(task_prio[slot]);
				pick  = slot;
				found = 1'b1;
			end
		end
		if (found) begin
			if (task_prio[pick] == lvl_max) begin
				for (int i = 0; i < NUM_ENTRIES; i++) begin
					if (task_state[i] == ST_RUNNABLE) begin
						task_prio[i] = lvl_min;
					end
				end
				rst_cnt++;
			end else if (task_ran[pick]) begin
				task_prio[pick] = task_prio[pick] + 1'b1;
			end
			task_ran[pick]  = 1'b1;
			d.decision      = DEC_RUN;
			d.chosen_index  = pick[FIELD_IDX_W-1:0];
			return d;
		end
		if (r.current_valid && r.current_on_this_cpu &&
		    int'(r.current_index) < NUM_ENTRIES &&
		    task_state[r.current_index] == ST_RUNNING) begin
			d.decision     = DEC_KEEP;
			d.chosen_index = r.current_index;
			return d;
		end
		d.decision = DEC_NONE;
		for (int i = 0; i < NUM_ENTRIES; i++) begin
			if (task_state[i] == ST_RUNNABLE || task_state[i] == ST_RUNNING ||
			    task_state[i] == ST_DYING) begin
				d.decision = DEC_HALT;
			end
		end
		return d;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_ENTRIES; i++) begin
				task_state[i] = ST_FREE;
				task_prio[i]  = '0;
				task_ran[i]   = 1'b0;
			end
			lvl_min = 4'd1;
			lvl_max = 4'd10;
			decisions_due.delete();
			err_cnt = 0;
			chk_cnt = 0;
			rst_cnt = 0;
			errors  <= 0;
			pending <= 0;
			checked <= 0;
			resets  <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (decisions_due.size() == 0) begin
					flag($sformatf("checker: decision %0d index %0d with none expected",
						rsp.decision, rsp.chosen_index));
				end else begin
					if (rsp.decision != decisions_due[0].decision) begin
						flag($sformatf("checker: decision expected %0d got %0d",
							decisions_due[0].decision, rsp.decision));
					end
					if (rsp.chosen_index != decisions_due[0].chosen_index) begin
						flag($sformatf("checker: index expected %0d got %0d (decision %0d)",
							decisions_due[0].chosen_index, rsp.chosen_index,
							decisions_due[0].decision));
					end
					void'(decisions_due.pop_front());
					chk_cnt++;
				end
			end
			if (req_valid && !req_stall) begin
				case (req.opcode)
					OP_SET_STATUS: begin
						if (int'(req.entry_index) < NUM_ENTRIES) begin
							task_state[req.entry_index] = req.entry_state;
						end
					end
					OP_CREATE: begin
						if (int'(req.entry_index) < NUM_ENTRIES) begin
							task_state[req.entry_index] = req.entry_state;
							task_prio[req.entry_index]  = req.entry_priority;
							task_ran[req.entry_index]   = 1'b0;
						end
					end
					OP_SCHEDULE: begin
						decisions_due.push_back(schedule_decision(req));
					end
					default: begin
					end
				endcase
			end
			if (psel && penable && pready) begin
				if (pwrite) begin
					if (paddr[2] == REG_PRIO_MIN) begin
						lvl_min = pwdata[PRIO_W-1:0];
					end else begin
						lvl_max = pwdata[PRIO_W-1:0];
					end
				end else if (prdata[PRIO_W-1:0] !=
				             ((paddr[2] == REG_PRIO_MIN) ? lvl_min : lvl_max)) begin
					flag($sformatf("checker: register %0d read %0d expected %0d", paddr[2],
						prdata[PRIO_W-1:0],
						(paddr[2] == REG_PRIO_MIN) ? lvl_min : lvl_max));
				end
			end
			errors  <= err_cnt;
			pending <= decisions_due.size();
			checked <= chk_cnt;
			resets  <= rst_cnt;
		end
	end

endmodule

/* sim/tb.sv */
// Top of the priority scheduler testbench: clock, reset, request and
// register stimulus, result-side stalls and the verdict.
// Depends on psa_pkg, psa_checker and priority_scheduler_with_aging.
`timescale 1ns / 1ps

module tb;
	import psa_pkg::*;

	// Codes the package leaves unnamed.
	localparam logic [1:0]      OP_UNUSED  = 2'd3;
	localparam logic [ST_W-1:0] ST_BLOCKED = 3'd4;

	localparam int unsigned CYCLE_LIMIT    = 1_000_000;
	localparam int          NUM_PHASES     = 8;
	localparam int          PHASE_REQUESTS = 150;
	localparam int          POOL_SIZE      = 12;
	localparam int          HOLD_CYCLES    = 400;

	// Register settings per phase; phases 5 and 6 draw random levels.
	localparam logic [PRIO_W-1:0] LEVEL_LO [NUM_PHASES] = '{0, 15, 0, 15, 1, 0, 0, 3};
	localparam logic [PRIO_W-1:0] LEVEL_HI [NUM_PHASES] = '{15, 0, 0, 15, 10, 0, 0, 7};

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_TOGGLE
	} stall_mode_e;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        req_valid = 1'b0;
	req_t        req       = '0;
	logic        rsp_stall = 1'b0;
	logic        psel      = 1'b0;
	logic        penable   = 1'b0;
	logic        pwrite    = 1'b0;
	logic [2:0]  paddr     = '0;
	logic [31:0] pwdata    = '0;
	logic        hold_go   = 1'b0;

	logic        req_stall;
	logic        rsp_valid;
	rsp_t        rsp;
	logic [31:0] prdata;
	logic        pready;

	int unsigned errors;
	int unsigned pending;
	int unsigned checked;
	int unsigned resets;

	int unsigned       cycles        = 0;
	int unsigned       accepted      = 0;
	int unsigned       sched_sent    = 0;
	int unsigned       burst_left    = 0;
	int unsigned       pool [POOL_SIZE];
	logic [PRIO_W-1:0] cur_max       = 4'd10;

	// Result-side stall state, owned by the stall process.
	stall_mode_e stall_mode = STALL_NONE;
	int unsigned mode_left  = 0;
	int unsigned hold_left  = 0;
	bit          hold_used  = 1'b0;

	priority_scheduler_with_aging DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	psa_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.errors    (errors),
		.pending   (pending),
		.checked   (checked),
		.resets    (resets)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Bound the run; a hang anywhere ends here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb: timeout after %0d cycles, %0d decisions outstanding", cycles, pending);
			$display("tb: done, errors");
			$finish;
		end
	end

	// Stall the result side: switch between idle, light, heavy and toggling
	// patterns, and once hold off for a long stretch so the block backs up
	// into its request input.
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else if (hold_left > 0) begin
			rsp_stall <= 1'b1;
			hold_left--;
		end else if (hold_go && !hold_used) begin
			hold_used = 1'b1;
			hold_left = HOLD_CYCLES;
			rsp_stall <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				stall_mode = stall_mode_e'($urandom_range(0, 3));
				mode_left  = $urandom_range(64, 256);
			end else begin
				mode_left--;
			end
			case (stall_mode)
				STALL_NONE:  rsp_stall <= 1'b0;
				STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
				STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
				default:     rsp_stall <= ~rsp_stall;
			endcase
		end
	end

	function automatic req_t mk(input logic [1:0] op, input int idx,
	                            input logic [ST_W-1:0] st,
	                            input int pr, input logic cv, input int ci,
	                            input logic oc);
		req_t r;
		r.opcode              = op;
		r.entry_index         = idx[FIELD_IDX_W-1:0];
		r.entry_state         = st;
		r.entry_priority      = pr[PRIO_W-1:0];
		r.current_valid       = cv;
		r.current_index       = ci[FIELD_IDX_W-1:0];
		r.current_on_this_cpu = oc;
		return r;
	endfunction

	// Status mix for pool entries: mostly runnable or running, with some
	// dying, free, blocked and unknown codes.
	function automatic logic [ST_W-1:0] pool_state();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 35) return ST_RUNNABLE;
		if (roll < 55) return ST_RUNNING;
		if (roll < 65) return ST_DYING;
		if (roll < 80) return ST_FREE;
		if (roll < 90) return ST_BLOCKED;
		return ST_W'($urandom_range(5, 7));
	endfunction

	// One random request. Most traffic works a small pool of entries so
	// that picks, aging and priority resets interact; the rest is stray
	// writes elsewhere and the unused opcode.
	function automatic req_t random_request();
		req_t r;
		int   roll;
		roll                  = $urandom_range(0, 99);
		r.entry_index         = FIELD_IDX_W'(pool[$urandom_range(0, POOL_SIZE - 1)]);
		r.entry_state         = ST_W'($urandom_range(0, 7));
		r.entry_priority      = PRIO_W'($urandom_range(0, 15));
		r.current_valid       = ($urandom_range(0, 99) < 85);
		r.current_index       = FIELD_IDX_W'(($urandom_range(0, 99) < 70) ?
		                        pool[$urandom_range(0, POOL_SIZE - 1)] : $urandom_range(0, 63));
		r.current_on_this_cpu = ($urandom_range(0, 99) < 75);
		if (roll < 5) begin
			r.opcode = OP_UNUSED;
		end else if (roll < 35) begin
			r.opcode      = OP_CREATE;
			r.entry_state = pool_state();
			if ($urandom_range(0, 99) < 70) begin
				r.entry_priority = PRIO_W'($urandom_range(0, cur_max));
			end
		end else if (roll < 50) begin
			r.opcode      = OP_SET_STATUS;
			r.entry_state = pool_state();
		end else if (roll < 55) begin
			// Stray write: park an arbitrary entry in a state that never runs.
			r.opcode      = OP_SET_STATUS;
			r.entry_index = FIELD_IDX_W'($urandom_range(0, NUM_ENTRIES - 1));
			case ($urandom_range(0, 2))
				0:       r.entry_state = ST_FREE;
				1:       r.entry_state = ST_BLOCKED;
				default: r.entry_state = ST_W'($urandom_range(5, 7));
			endcase
		end else begin
			r.opcode = OP_SCHEDULE;
		end
		return r;
	endfunction

	// Offer one request and hold it until accepted. Keep valid up inside a
	// burst; drop it for a random gap once the burst runs out.
	task automatic offer(input req_t r);
		int unsigned gap;
		req       <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		accepted++;
		if (r.opcode == OP_SCHEDULE) sched_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(1, 10);
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) :
			                                            $urandom_range(0, 15);
		end
	endtask

	// Drain: drop valid, wait for every decision, then let any trailing
	// table write finish before the registers are touched.
	task automatic settle();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// One register access: setup phase, access phase, then an idle phase so
	// back-to-back calls never stack two updates on psel in one step.
	task automatic reg_access(input logic wr, input logic sel, input logic [PRIO_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {sel, 2'b00};
		pwdata  <= {28'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		int unsigned       counted;
		logic [PRIO_W-1:0] lo;
		logic [PRIO_W-1:0] hi;
		req_t              r;

		for (int i = 0; i < POOL_SIZE; i++) begin
			pool[i] = $urandom_range(0, NUM_ENTRIES - 1);
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset levels (min 1, max 10).
		// Empty table: no tasks, with and without a current task.
		offer(mk(OP_SCHEDULE, 0, 0, 0, 1'b0, 0, 1'b0));
		offer(mk(OP_SCHEDULE, 0, 0, 0, 1'b1, NUM_ENTRIES - 1, 1'b1));
		// Unused opcode with every field set: must change nothing.
		offer(mk(OP_UNUSED, NUM_ENTRIES - 1, 7, 15, 1'b1, NUM_ENTRIES - 1, 1'b1));
		// Running current task with nothing runnable: keep it, or halt when
		// it is on another processor.
		offer(mk(OP_CREATE, NUM_ENTRIES - 1, ST_RUNNING, 15, 1'b0, 0, 1'b0));
		offer(mk(OP_SCHEDULE, 0, 0, 0, 1'b1, NUM_ENTRIES - 1, 1'b1));
		offer(mk(OP_SCHEDULE, 0, 0, 0, 1'b1, NUM_ENTRIES - 1, 1'b0));
		// Dying entry only keeps the block out of no-tasks.
		offer(mk(OP_SET_STATUS, NUM_ENTRIES - 1, ST_FREE, 0, 1'b0, 0, 1'b0));
		offer(mk(OP_SET_STATUS, 0, ST_DYING, 0, 1'b0, 0, 1'b0));
		offer(mk(OP_SCHEDULE, 0, 0, 0, 1'b0, 0, 1'b1));
		// Tie at priority 3 from a scan starting after entry 9, then aging.
		offer(mk(OP_CREATE, 5, ST_RUNNABLE, 10, 1'b0, 0, 1'b0));
		offer(mk(OP_CREATE, 9, ST_RUNNABLE, 3, 1'b0, 0, 1'b0));
		offer(mk(OP_CREATE, 20, ST_RUNNABLE, 3, 1'b0, 0, 1'b0));
		offer(mk(OP_SCHEDULE, 0, 0, 0, 1'b1, 9, 1'b1));
		offer(mk(OP_SCHEDULE, 0, 0, 0, 1'b1, 9, 1'b1));
		offer(mk(OP_SCHEDULE, 0, 0, 0, 1'b1, 9, 1'b0));
		// Above the top level: never picked. Unknown status behaves as blocked.
		offer(mk(OP_CREATE, 1, ST_RUNNABLE, 11, 1'b0, 0, 1'b0));
		offer(mk(OP_SET_STATUS, 9, 7, 0, 1'b0, 0, 1'b0));
		offer(mk(OP_SET_STATUS, 20, ST_BLOCKED, 0, 1'b0, 0, 1'b0));
		// Pick at the top level: every runnable entry drops to the bottom.
		offer(mk(OP_SCHEDULE, 0, 0, 0, 1'b1, 40, 1'b1));
		offer(mk(OP_SCHEDULE, 0, 0, 0, 1'b0, 33, 1'b1));
		// Priority extremes on the first and last entry.
		offer(mk(OP_CREATE, NUM_ENTRIES - 1, ST_RUNNABLE, 0, 1'b0, 0, 1'b0));
		offer(mk(OP_CREATE, 0, 6, 15, 1'b0, 0, 1'b0));
		offer(mk(OP_SCHEDULE, 0, 0, 0, 1'b1, NUM_ENTRIES - 2, 1'b1));
		offer(mk(OP_SCHEDULE, 0, 0, 0, 1'b1, NUM_ENTRIES - 1, 1'b1));

		// Random phases, each under its own register setting.
		for (int p = 0; p < NUM_PHASES; p++) begin
			settle();
			lo = (p == 5 || p == 6) ? 4'($urandom_range(0, 15)) : LEVEL_LO[p];
			hi = (p == 5 || p == 6) ? 4'($urandom_range(0, 15)) : LEVEL_HI[p];
			reg_access(1'b1, REG_PRIO_MIN, lo);
			reg_access(1'b1, REG_PRIO_MAX, hi);
			reg_access(1'b0, REG_PRIO_MIN, '0);
			reg_access(1'b0, REG_PRIO_MAX, '0);
			cur_max = hi;
			// Start the long result hold while requests keep coming.
			if (p == 2) hold_go <= 1'b1;
			// Retire the old pool, then work a fresh one.
			for (int i = 0; i < POOL_SIZE; i++) begin
				offer(mk(OP_SET_STATUS, pool[i], ST_FREE, 0, 1'b0, 0, 1'b0));
				pool[i] = $urandom_range(0, NUM_ENTRIES - 1);
			end
			counted = 0;
			while (counted < PHASE_REQUESTS) begin
				r = random_request();
				offer(r);
				if (r.opcode != OP_UNUSED) counted++;
			end
		end

		settle();
		repeat (150) @(posedge clk);

		$display("tb: %0d requests accepted (%0d schedule), %0d decisions checked",
			accepted, sched_sent, checked);
		$display("tb: %0d global priority resets over %0d register settings",
			resets, NUM_PHASES);
		if (pending != 0) begin
			$display("tb: %0d decisions never arrived", pending);
		end
		if (errors == 0 && pending == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/psa_pkg.sv
rtl/core/psa_cfg.sv
rtl/core/psa_table.sv
rtl/core/priority_scheduler_with_aging.sv
sim/psa_checker.sv
sim/tb.sv
